/* rtl/ile_pkg.sv */
`default_nettype none

package ile_pkg;

    // Fixed widths of the request and response beats.
    localparam int OP_W     = 3;
    localparam int INDEX_W  = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [2:0]          cell_cmd_t;

    // Request operations.
    localparam op_t OP_INSERT     = 3'd0;
    localparam op_t OP_DELETE     = 3'd1;
    localparam op_t OP_READ       = 3'd2;
    localparam op_t OP_WRITE      = 3'd3;
    localparam op_t OP_FIND       = 3'd4;
    localparam op_t OP_DELETE_ALL = 3'd5;

    // Response status codes.
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_RANGE     = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_NOT_FOUND = 2'd3;

    // Commands broadcast to every cell of the chain.
    localparam cell_cmd_t CELL_HOLD   = 3'd0;
    localparam cell_cmd_t CELL_INSERT = 3'd1;
    localparam cell_cmd_t CELL_DELETE = 3'd2;
    localparam cell_cmd_t CELL_WRITE  = 3'd3;
    localparam cell_cmd_t CELL_ROTATE = 3'd4;

endpackage

`default_nettype wire

/* rtl/ile_ifs.sv */
`default_nettype none

interface ile_req_if;
    import ile_pkg::*;

    logic                       valid;
    logic                       ready;
    op_t                        op;
    logic signed [INDEX_W-1:0]  index;
    logic [VALUE_W-1:0]         value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink   (input valid, input op, input index, input value, output ready);
endinterface

interface ile_rsp_if;
    import ile_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  item_count;
    logic [COUNT_W-1:0]  removed_count;

    modport source (output valid, output status, output read_value, output item_count,
                    output removed_count, input ready);
    modport sink   (input valid, input status, input read_value, input item_count,
                    input removed_count, output ready);
endinterface

`default_nettype wire

/* rtl/ile_cell.sv */
`default_nettype none

module ile_cell #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  logic                          clk,
    input  ile_pkg::cell_cmd_t            cmd,
    input  logic [$clog2(DEPTH)-1:0]      pos,
    input  logic [WORD_WIDTH-1:0]         word_in,
    input  logic [WORD_WIDTH-1:0]         left,
    input  logic [WORD_WIDTH-1:0]         right,
    input  logic [WORD_WIDTH-1:0]         head,
    output logic [WORD_WIDTH-1:0]         q
);
    import ile_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [WORD_WIDTH-1:0] word_reg;
    logic [WORD_WIDTH-1:0] word_next;

    // Each cell decides from its own position which neighbor it copies.
    always_comb
    begin
        word_next = word_reg;
        unique case (cmd)
            CELL_INSERT:
            begin
                if (MY_IDX > pos)
                    word_next = left;
                else if (MY_IDX == pos)
                    word_next = word_in;
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= pos)
                    word_next = right;
            end
            CELL_WRITE:
            begin
                if (MY_IDX == pos)
                    word_next = word_in;
            end
            CELL_ROTATE:
            begin
                if (MY_IDX < pos)
                    word_next = right;
                else if (MY_IDX == pos)
                    word_next = head;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

`default_nettype wire

/* rtl/indexed_list_engine.sv */
`default_nettype none

// Channel  Dir  Beat contents                                      Handshake
// req      in   op, index (signed), value                          valid/ready
// rsp      out  status, read_value, item_count, removed_count      valid/ready
//
// Insert, delete-at, write and the unused codes pass from the accepted beat through the
// execute and finish states to the output register; an in-range read, and a find or a
// delete-all on a non-empty list, first rotate the list once through cell 0 in the scan state.
// The next beat is accepted once the engine is idle, even while the previous result
// is unread; a finished result then waits, and blocks input, until the output frees.
// Reset clears only the length and the control state; stored words are unknown until written.

module indexed_list_engine #(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    ile_req_if.sink       req,
    ile_rsp_if.source     rsp
);
    import ile_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH + 1);
    // Signed width that holds both the sign-extended index and the length.
    localparam int RES_W = ((LEN_W > INDEX_W) ? LEN_W : INDEX_W) + 2;
    localparam int EXT_W = (WORD_WIDTH > VALUE_W) ? WORD_WIDTH : VALUE_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // Control state.
    logic [1:0]            state_reg, state_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic                  out_valid_reg, out_valid_next;

    // Latched request, already resolved against the length at accept time.
    op_t                   op_reg;
    logic                  neg_reg;
    logic                  inrange_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [WORD_WIDTH-1:0] word_reg;

    // Scan bookkeeping and the pending result.
    logic [IDX_W-1:0]      step_reg, step_next;
    logic [IDX_W-1:0]      last_reg, last_next;
    status_t               res_status_reg, res_status_next;
    logic [WORD_WIDTH-1:0] res_rv_reg, res_rv_next;
    logic [LEN_W-1:0]      res_removed_reg, res_removed_next;

    // Output register.
    status_t               out_status_reg;
    logic [VALUE_W-1:0]    out_rv_reg;
    logic [COUNT_W-1:0]    out_count_reg;
    logic [COUNT_W-1:0]    out_removed_reg;
    logic                  out_load;

    // Index resolution.
    logic signed [RES_W-1:0] idx_ext, len_ext, res_idx, res_clamp;
    logic                    res_neg, res_inrange, req_fire;
    logic [EXT_W-1:0]        value_ext;
    logic [EXT_W-1:0]        rv_ext;

    // Cell chain.
    cell_cmd_t             cmd;
    logic [IDX_W-1:0]      cmd_pos;
    logic [WORD_WIDTH-1:0] words   [DEPTH];
    logic [WORD_WIDTH-1:0] left_w  [DEPTH];
    logic [WORD_WIDTH-1:0] right_w [DEPTH];
    logic [WORD_WIDTH-1:0] head;
    logic                  hit;
    logic [LEN_W-1:0]      len_m1;
    logic [IDX_W-1:0]      tail;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    // A negative index has the length added; an insert index past the end clamps
    // to the end, which appends.
    assign idx_ext     = {{(RES_W-INDEX_W){req.index[INDEX_W-1]}}, req.index};
    assign len_ext     = {{(RES_W-LEN_W){1'b0}}, len_reg};
    assign res_idx     = idx_ext + (req.index[INDEX_W-1] ? len_ext : '0);
    assign res_neg     = res_idx[RES_W-1];
    assign res_inrange = !res_neg && (res_idx < len_ext);
    assign res_clamp   = (res_idx > len_ext) ? len_ext : res_idx;
    assign value_ext   = EXT_W'(req.value);

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            op_reg      <= req.op;
            neg_reg     <= res_neg;
            inrange_reg <= res_inrange;
            pos_reg     <= res_clamp[IDX_W-1:0];
            word_reg    <= value_ext[WORD_WIDTH-1:0];
        end
    end

    // Cell 0 is the head of the list; a rotation moves it to the current tail.
    assign head   = words[0];
    assign hit    = (head == word_reg);
    assign len_m1 = len_reg - LEN_W'(1);
    assign tail   = len_m1[IDX_W-1:0];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign left_w[g] = '0;
        end
        else
        begin : g_mid_left
            assign left_w[g] = words[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_w[g] = '0;
        end
        else
        begin : g_mid_right
            assign right_w[g] = words[g+1];
        end

        ile_cell #(
            .DEPTH      (DEPTH),
            .WORD_WIDTH (WORD_WIDTH),
            .IDX        (g)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .pos     (cmd_pos),
            .word_in (word_reg),
            .left    (left_w[g]),
            .right   (right_w[g]),
            .head    (head),
            .q       (words[g])
        );
    end

    // Sequencer. Single-position operations act on every cell at the same edge. Read,
    // find and delete-all rotate the whole list once through cell 0, so each word
    // is examined at a fixed place; delete-all drops a matching head instead of
    // rotating it, which compacts the list while keeping the order of the rest.
    always_comb
    begin
        state_next       = state_reg;
        len_next         = len_reg;
        cmd              = CELL_HOLD;
        cmd_pos          = pos_reg;
        step_next        = step_reg;
        last_next        = last_reg;
        res_status_next  = res_status_reg;
        res_rv_next      = res_rv_reg;
        res_removed_next = res_removed_reg;
        out_load         = 1'b0;
        out_valid_next   = out_valid_reg && !rsp.ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_status_next  = ST_OK;
                res_rv_next      = '0;
                res_removed_next = '0;
                step_next        = '0;
                last_next        = tail;
                state_next       = S_FIN;
                unique case (op_reg) inside
                    OP_INSERT:
                    begin
                        if (neg_reg)
                            res_status_next = ST_RANGE;
                        else if (len_reg == LEN_W'(DEPTH))
                            res_status_next = ST_FULL;
                        else
                        begin
                            cmd      = CELL_INSERT;
                            len_next = len_reg + LEN_W'(1);
                        end
                    end
                    OP_DELETE:
                    begin
                        if (!inrange_reg)
                            res_status_next = ST_RANGE;
                        else
                        begin
                            cmd              = CELL_DELETE;
                            len_next         = len_m1;
                            res_removed_next = LEN_W'(1);
                        end
                    end
                    OP_WRITE:
                    begin
                        if (!inrange_reg)
                            res_status_next = ST_RANGE;
                        else
                            cmd = CELL_WRITE;
                    end
                    OP_READ:
                    begin
                        if (!inrange_reg)
                            res_status_next = ST_RANGE;
                        else
                            state_next = S_SCAN;
                    end
                    OP_FIND, OP_DELETE_ALL:
                    begin
                        res_status_next = ST_NOT_FOUND;
                        if (len_reg != '0)
                            state_next = S_SCAN;
                    end
                    default:
                    begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            S_SCAN:
            begin
                step_next = step_reg + IDX_W'(1);
                if (step_reg == last_reg)
                    state_next = S_FIN;
                unique case (op_reg) inside
                    OP_READ:
                    begin
                        cmd     = CELL_ROTATE;
                        cmd_pos = tail;
                        if (step_reg == pos_reg)
                            res_rv_next = head;
                    end
                    OP_FIND:
                    begin
                        cmd     = CELL_ROTATE;
                        cmd_pos = tail;
                        if (hit)
                        begin
                            res_status_next = ST_OK;
                            res_rv_next     = head;
                        end
                    end
                    OP_DELETE_ALL:
                    begin
                        if (hit)
                        begin
                            cmd              = CELL_DELETE;
                            cmd_pos          = '0;
                            len_next         = len_m1;
                            res_removed_next = res_removed_reg + LEN_W'(1);
                            res_status_next  = ST_OK;
                        end
                        else
                        begin
                            cmd     = CELL_ROTATE;
                            cmd_pos = tail;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_FIN:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rv_ext = EXT_W'(res_rv_reg);

    always_ff @(posedge clk)
    begin
        step_reg        <= step_next;
        last_reg        <= last_next;
        res_status_reg  <= res_status_next;
        res_rv_reg      <= res_rv_next;
        res_removed_reg <= res_removed_next;
        if (out_load)
        begin
            out_status_reg  <= res_status_reg;
            out_rv_reg      <= rv_ext[VALUE_W-1:0];
            out_count_reg   <= COUNT_W'(len_reg);
            out_removed_reg <= COUNT_W'(res_removed_reg);
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.read_value    = out_rv_reg;
    assign rsp.item_count    = out_count_reg;
    assign rsp.removed_count = out_removed_reg;

endmodule

`default_nettype wire

/* rtl/ile_checker.sv */
`default_nettype none

module ile_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  ile_pkg::status_t              status,
    input  logic [ile_pkg::VALUE_W-1:0]   read_value,
    input  logic [ile_pkg::COUNT_W-1:0]   item_count,
    input  logic [ile_pkg::COUNT_W-1:0]   removed_count
);
    import ile_pkg::*;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(status) && $stable(read_value)
            && $stable(item_count) && $stable(removed_count))
        else $error("response beat changed while stalled");

    // Removing entries only happens on a successful operation.
    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (removed_count != '0) |-> status == ST_OK)
        else $error("entries removed with a failure status");

    // A nonzero word is only returned by a successful read or find.
    a_value_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (read_value != '0) |-> status == ST_OK)
        else $error("data word returned with a failure status");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .read_value    (rsp.read_value),
    .item_count    (rsp.item_count),
    .removed_count (rsp.removed_count)
);

`default_nettype wire
